### rtl/core/hsfc_pkg.sv
// Package for the binary16/binary32 converter: payload types, constants, helpers.
// No dependencies.
package hsfc_pkg;

   localparam logic REQ_S2H = 1'b0;
   localparam logic REQ_H2S = 1'b1;

   localparam logic [15:0] HALF_QNAN = 16'h7e00;
   localparam logic [15:0] HALF_INF  = 16'h7c00;
   localparam logic [7:0]  SINGLE_EXP_MAX = 8'hff;
   localparam logic [4:0]  HALF_EXP_MAX = 5'h1f;

   typedef struct packed {
      logic        req_type;
      logic [31:0] single_bits;
      logic [15:0] half_bits;
   } req_type_type;

   typedef struct packed {
      logic [31:0] result_bits;
   } rsp_type;

   // Stage 1 to stage 2: decoded fields and case flags.
   typedef struct packed {
      logic        dir;
      logic        sign;
      logic        special;     // result fully known already
      logic [31:0] fixed;       // that result
      logic [4:0]  hexp;        // binary16 exponent for normal results
      logic        sub;         // binary16 subnormal result
      logic [3:0]  shift;       // 1..11 for subnormal results
      logic [23:0] mant;        // significand with hidden bit
      logic [9:0]  hm;          // half mantissa for normalisation
   } s1_type;

   // Stage 2 to stage 3: truncated result and rounding decision.
   typedef struct packed {
      logic        dir;
      logic        sign;
      logic        special;
      logic [31:0] fixed;
      logic [4:0]  hexp;
      logic        sub;
      logic [10:0] trunc;
      logic        round_up;
      logic [3:0]  lz;          // leading zeros of a half subnormal
      logic [9:0]  hm;
   } s2_type;

endpackage

### rtl/core/hsfc_if.sv
// Valid/ready channel carrying one payload of a given type.
// No dependencies; the payload type is a parameter.
interface hsfc_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/hsfc_decode.sv
// First stage logic: field decode and classification of the operand.
// Depends on hsfc_pkg.
module hsfc_decode (
   input  hsfc_pkg::req_type_type req,
   output hsfc_pkg::s1_type       dec
);
   import hsfc_pkg::*;

   logic [7:0] e;
   logic [22:0] m;
   logic [4:0] he5;
   logic [9:0] he;   // biased exponent minus 112, two's complement

   always_comb begin
      e   = req.single_bits[30:23];
      m   = req.single_bits[22:0];
      he  = {2'b00, e} - 10'd112;
      he5 = req.half_bits[14:10];
      dec = '0;
      dec.dir  = req.req_type;
      dec.mant = {1'b1, m};
      dec.hm   = req.half_bits[9:0];
      if (req.req_type == REQ_S2H) begin
         dec.sign = req.single_bits[31];
         dec.hexp = he[4:0];
         dec.fixed = {16'h0, req.single_bits[31], 15'h0};
         if (e == SINGLE_EXP_MAX) begin
            dec.special = 1'b1;
            dec.fixed[14:0] = (m != '0) ? HALF_QNAN[14:0] : HALF_INF[14:0];
         end else if (!he[9] && he >= 10'd31) begin
            dec.special = 1'b1;
            dec.fixed[14:0] = HALF_INF[14:0];
         end else if (he[9] || he == '0) begin
            if (he[9] && he < 10'h3f6) begin
               dec.special = 1'b1;   // below half the smallest subnormal
            end else begin
               dec.sub = 1'b1;
               dec.shift = 4'(10'd1 - he);
            end
         end
      end else begin
         dec.sign = req.half_bits[15];
         dec.fixed = {req.half_bits[15], 31'h0};
         if (he5 == HALF_EXP_MAX) begin
            dec.special = 1'b1;
            dec.fixed[30:0] = {8'hff, req.half_bits[9:0], 13'h0};
         end else if (he5 != '0) begin
            dec.special = 1'b1;
            dec.fixed[30:0] = {8'(he5) + 8'd112, req.half_bits[9:0], 13'h0};
         end else if (req.half_bits[9:0] == '0) begin
            dec.special = 1'b1;
         end
      end
   end
endmodule

### rtl/core/hsfc_round.sv
// Second stage logic: truncation, rounding decision, subnormal leading-zero count.
// Depends on hsfc_pkg.
module hsfc_round (
   input  hsfc_pkg::s1_type s1,
   output hsfc_pkg::s2_type s2
);
   import hsfc_pkg::*;

   logic [23:0] rmask;
   logic        rbit, sticky;

   always_comb begin
      s2 = '0;
      s2.dir = s1.dir;
      s2.sign = s1.sign;
      s2.special = s1.special;
      s2.fixed = s1.fixed;
      s2.hexp = s1.hexp;
      s2.sub = s1.sub;
      s2.hm = s1.hm;
      rmask = '0;
      rbit = 1'b0;
      if (s1.sub) begin
         s2.trunc = 11'(s1.mant >> (5'(s1.shift) + 5'd13));
         rbit = s1.mant[5'(s1.shift) + 5'd12];
         rmask = (24'd1 << (5'(s1.shift) + 5'd12)) - 24'd1;
      end else begin
         s2.trunc = {1'b0, s1.mant[22:13]};
         rbit = s1.mant[12];
         rmask = 24'h000fff;
      end
      sticky = (s1.mant & rmask) != '0;
      s2.round_up = rbit && (sticky || s2.trunc[0]);
      s2.lz = 4'd10;
      for (int i = 0; i < 10; i++) begin
         if (s1.hm[i]) s2.lz = 4'(9 - i);
      end
   end
endmodule

### rtl/core/hsfc_pack.sv
// Third stage logic: apply rounding with carry, normalise half subnormals, pack.
// Depends on hsfc_pkg.
module hsfc_pack (
   input  hsfc_pkg::s2_type s2,
   output hsfc_pkg::rsp_type rsp
);
   import hsfc_pkg::*;

   logic [11:0] sum;
   logic [5:0]  ex;
   logic [9:0]  nm;

   always_comb begin
      sum = {1'b0, s2.trunc} + {11'h0, s2.round_up};
      ex  = {1'b0, s2.hexp} + {5'h0, sum[10]};
      nm  = s2.hm << (5'(s2.lz) + 5'd1);
      if (s2.special) begin
         rsp.result_bits = s2.fixed;
      end else if (s2.dir == REQ_H2S) begin
         rsp.result_bits = {s2.sign, 8'd113 - 8'(s2.lz) - 8'd1, nm, 13'h0};
      end else if (s2.sub) begin
         // A carry out of the subnormal field lands on the smallest normal.
         rsp.result_bits = {16'h0, s2.sign, 4'h0, sum[10:0]};
      end else if (ex >= 6'd31) begin
         rsp.result_bits = {16'h0, s2.sign, HALF_INF[14:0]};
      end else begin
         rsp.result_bits = {16'h0, s2.sign, ex[4:0], sum[9:0]};
      end
   end
endmodule

### rtl/core/half_single_float_converter_top.sv
// Binary16/binary32 converter, three register stages (decode, round, pack), the last
// of which is the output register; one request per cycle, the whole pipeline
// advancing unless the last stage holds an untaken result.
// Depends on hsfc_pkg, hsfc_if, hsfc_decode, hsfc_round and hsfc_pack.
module half_single_float_converter_top (
   input  logic clock,
   input  logic reset,
   hsfc_if.sink   req,
   hsfc_if.source rsp
);
   import hsfc_pkg::*;

   s1_type  s1_ff, s1_in;
   s2_type  s2_ff, s2_in;
   rsp_type o_ff, o_in;
   logic v1_ff, v2_ff, v3_ff;
   logic adv;

   assign adv = !v3_ff || rsp.ready;
   assign req.ready = adv;
   assign rsp.valid = v3_ff;
   assign rsp.data  = o_ff;

   hsfc_decode u_dec (.req(req.data), .dec(s1_in));
   hsfc_round  u_rnd (.s1(s1_ff), .s2(s2_in));
   hsfc_pack   u_pck (.s2(s2_ff), .rsp(o_in));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         o_ff  <= o_in;
      end
   end
endmodule
